// ----- src/least_squares_line_calibrator_assert.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the least-squares line calibrator
// Immediate-consequence and next-cycle implication checks on aclk.
// ----------------------------------------------------------------------------
`ifndef LEAST_SQUARES_LINE_CALIBRATOR_ASSERT_SVH
`define LEAST_SQUARES_LINE_CALIBRATOR_ASSERT_SVH

`ifndef NO_ASSERTIONS

`define LSLC_ASSERT_IMP(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

`define LSLC_ASSERT_NXT(name, clk, rstn, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`else

`define LSLC_ASSERT_IMP(name, clk, rstn, ante, cons, msg)

`define LSLC_ASSERT_NXT(name, clk, rstn, ante, cons, msg)

`endif

`endif

// ----- src/lslc_pkg.sv -----
// ----------------------------------------------------------------------------
// lslc_pkg
// Widths, codes and controller/datapath interface types of the calibrator.
// ----------------------------------------------------------------------------
`default_nettype none

package lslc_pkg;

    localparam int MAX_POINTS = 16;
    localparam int CNT_W      = $clog2(MAX_POINTS + 1);
    localparam int LOG_N      = $clog2(MAX_POINTS);

    localparam int OP_W   = 2;
    localparam int X_W    = 10;
    localparam int Y_W    = 16;
    localparam int COEF_W = 32;
    localparam int PTS_W  = 5;
    localparam int STAT_W = 2;

    localparam int SX_W   = X_W + LOG_N;
    localparam int SY_W   = Y_W + LOG_N + 1;
    localparam int SXX_W  = 2 * X_W + LOG_N + 1;
    localparam int SXY_W  = X_W + Y_W + LOG_N + 1;

    localparam int MUL_W  = (SXY_W > COEF_W) ? SXY_W : COEF_W;
    localparam int PROD_W = 2 * MUL_W;
    localparam int ACC_W  = PROD_W + 1;
    localparam int DEN_W  = ACC_W - 1;
    localparam int REM_W  = DEN_W + 1;

    localparam int SH_SLOPE = 16;
    localparam int SH_ICPT  = 8;
    localparam int Q_W      = COEF_W + 1;
    localparam int DIVD_W   = ACC_W + SH_SLOPE + 1;
    localparam int DCNT_W   = $clog2(Q_W);

    localparam int CONV_SH  = 8;
    localparam int RND_HALF = 1 << (CONV_SH - 1);
    localparam int RND_W    = PROD_W + 1 - CONV_SH;

    localparam logic signed [COEF_W-1:0] COEF_MAX = {1'b0, {(COEF_W-1){1'b1}}};
    localparam logic signed [COEF_W-1:0] COEF_MIN = {1'b1, {(COEF_W-1){1'b0}}};
    localparam logic [Q_W-1:0] Q_POS_LIM = {1'b0, COEF_MAX};
    localparam logic [Q_W-1:0] Q_NEG_LIM = {1'b0, COEF_MIN};

    localparam logic [CNT_W-1:0] CNT_MAX  = CNT_W'(MAX_POINTS);
    localparam logic [PTS_W-1:0] PTS_FULL = PTS_W'(MAX_POINTS);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 2'd0,
        OP_FIT  = 2'd1,
        OP_CONV = 2'd2,
        OP_SET  = 2'd3
    } op_t;

    typedef enum logic [STAT_W-1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_DEGEN = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        MUL_XX      = 4'd0,
        MUL_XY      = 4'd1,
        MUL_N_SXX   = 4'd2,
        MUL_SX_SX   = 4'd3,
        MUL_N_SXY   = 4'd4,
        MUL_SX_SY   = 4'd5,
        MUL_SY_SXX  = 4'd6,
        MUL_SX_SXY  = 4'd7,
        MUL_SLOPE_X = 4'd8
    } mul_sel_t;

    typedef struct packed {
        logic     capture;
        mul_sel_t mul_sel;
        logic     sxx_add;
        logic     sums_upd;
        logic     acc_load;
        logic     den_load;
        logic     nums_load;
        logic     numb_load;
        logic     div_start;
        logic     div_sel_b;
        logic     slope_wr;
        logic     icpt_wr;
        logic     coef_set;
        logic     conv_rnd;
        logic     conv_sum;
        logic     out_load;
        status_t  out_status;
    } lslc_cmd_t;

    typedef struct packed {
        op_t  op;
        logic full;
        logic den_pos;
        logic div_done;
    } lslc_sts_t;

endpackage

`default_nettype wire

// ----- src/least_squares_line_calibrator.sv -----
// ----------------------------------------------------------------------------
// least_squares_line_calibrator
// Accumulates calibration points and fits, applies or loads a straight line.
// ----------------------------------------------------------------------------
// One word is in flight at a time; each input word yields one result word.
// A full fit runs the shared restoring divider, which produces one of its
// 33 quotient bits per cycle and runs once for the slope and once for the
// intercept. A new word is taken as soon as the previous result sits in
// the output register, even if the result has not yet been taken.
`default_nettype none

`include "least_squares_line_calibrator_assert.svh"

module least_squares_line_calibrator import lslc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     s_valid,
    output logic                     s_ready,
    input  logic [OP_W-1:0]          s_op,
    input  logic [X_W-1:0]           s_adc_value,
    input  logic signed [Y_W-1:0]    s_dielectric_in,
    input  logic signed [COEF_W-1:0] s_slope_in,
    input  logic signed [COEF_W-1:0] s_intercept_in,
    output logic                     m_valid,
    input  logic                     m_ready,
    output logic [STAT_W-1:0]        m_status,
    output logic [PTS_W-1:0]         m_points_held,
    output logic signed [COEF_W-1:0] m_slope_out,
    output logic signed [COEF_W-1:0] m_intercept_out,
    output logic signed [COEF_W-1:0] m_dielectric_out
);

    lslc_cmd_t cmd;
    lslc_sts_t sts;

    lslc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .sts     (sts),
        .cmd     (cmd)
    );

    lslc_dpath u_dpath (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .cmd              (cmd),
        .sts              (sts),
        .s_op             (s_op),
        .s_adc_value      (s_adc_value),
        .s_dielectric_in  (s_dielectric_in),
        .s_slope_in       (s_slope_in),
        .s_intercept_in   (s_intercept_in),
        .m_status         (m_status),
        .m_points_held    (m_points_held),
        .m_slope_out      (m_slope_out),
        .m_intercept_out  (m_intercept_out),
        .m_dielectric_out (m_dielectric_out)
    );

    `LSLC_ASSERT_NXT(a_one_in_flight, aclk, aresetn, s_valid && s_ready, !s_ready,
        "input accepted while a word is in flight")
    `LSLC_ASSERT_IMP(a_full_at_max, aclk, aresetn, m_valid && (m_status == ST_FULL),
        m_points_held == PTS_FULL, "store-full status with point store not full")
    `LSLC_ASSERT_IMP(a_ready_on_result, aclk, aresetn, $rose(m_valid), s_ready,
        "result posted without returning to accept")

endmodule

`default_nettype wire

// ----- src/lslc_div.sv -----
// ----------------------------------------------------------------------------
// lslc_div
// Rounded, saturating restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module lslc_div import lslc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  logic                     start,
    input  logic                     sel_b,
    input  logic signed [ACC_W-1:0]  num,
    input  logic        [DEN_W-1:0]  den,
    output logic                     done,
    output logic signed [COEF_W-1:0] quot
);

    typedef enum logic [4:0] {
        D_IDLE = 5'b00001,
        D_HALF = 5'b00010,
        D_CHK  = 5'b00100,
        D_RUN  = 5'b01000,
        D_FIN  = 5'b10000
    } div_state_t;

    div_state_t          state_reg, state_next;
    logic                neg_reg;
    logic                ovf_reg;
    logic [DIVD_W-1:0]   dvd_reg;
    logic [REM_W-1:0]    rem_reg;
    logic [Q_W-1:0]      q_reg;
    logic [DCNT_W-1:0]   cnt_reg;

    logic [ACC_W-1:0]    mag;
    logic [DIVD_W-1:0]   dvd_start;
    logic [REM_W-1:0]    top_ext;
    logic [REM_W-1:0]    den_ext;
    logic                ovf_now;
    logic [REM_W-1:0]    trial;
    logic                fits;
    logic [COEF_W-1:0]   q_lo;

    assign mag       = num[ACC_W-1] ? ACC_W'(-num) : ACC_W'(num);
    assign dvd_start = sel_b ? (DIVD_W'(mag) << SH_ICPT) : (DIVD_W'(mag) << SH_SLOPE);
    assign top_ext   = REM_W'(dvd_reg[DIVD_W-1:Q_W]);
    assign den_ext   = REM_W'(den);
    assign ovf_now   = top_ext >= den_ext;
    assign trial     = {rem_reg[REM_W-2:0], q_reg[Q_W-1]};
    assign fits      = trial >= den_ext;
    assign q_lo      = q_reg[COEF_W-1:0];
    assign done      = (state_reg == D_FIN);

    always_comb begin
        if (!neg_reg) begin
            quot = (ovf_reg || (q_reg > Q_POS_LIM)) ? COEF_MAX : $signed(q_lo);
        end else begin
            quot = (ovf_reg || (q_reg > Q_NEG_LIM)) ? COEF_MIN : -$signed(q_lo);
        end
    end

    always_comb begin
        state_next = state_reg;
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    state_next = D_HALF;
                end
            end
            D_HALF: state_next = D_CHK;
            D_CHK: begin
                state_next = ovf_now ? D_FIN : D_RUN;
            end
            D_RUN: begin
                if (cnt_reg == DCNT_W'(Q_W - 1)) begin
                    state_next = D_FIN;
                end
            end
            D_FIN:   state_next = D_IDLE;
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_ff @(posedge aclk) begin
        unique case (state_reg)
            D_IDLE: begin
                if (start) begin
                    neg_reg <= num[ACC_W-1];
                    dvd_reg <= dvd_start;
                end
            end
            D_HALF: begin
                dvd_reg <= dvd_reg + DIVD_W'(den >> 1);
            end
            D_CHK: begin
                ovf_reg <= ovf_now;
                rem_reg <= top_ext;
                q_reg   <= dvd_reg[Q_W-1:0];
                cnt_reg <= '0;
            end
            D_RUN: begin
                if (fits) begin
                    rem_reg <= trial - den_ext;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b1};
                end else begin
                    rem_reg <= trial;
                    q_reg   <= {q_reg[Q_W-2:0], 1'b0};
                end
                cnt_reg <= cnt_reg + DCNT_W'(1);
            end
            default: begin
            end
        endcase
    end

endmodule

`default_nettype wire

// ----- src/lslc_dpath.sv -----
// ----------------------------------------------------------------------------
// lslc_dpath
// Running sums, coefficients, shared multiplier, divider and result word.
// ----------------------------------------------------------------------------
`default_nettype none

module lslc_dpath import lslc_pkg::*; (
    input  logic                     aclk,
    input  logic                     aresetn,
    input  lslc_cmd_t                cmd,
    output lslc_sts_t                sts,
    input  logic [OP_W-1:0]          s_op,
    input  logic [X_W-1:0]           s_adc_value,
    input  logic signed [Y_W-1:0]    s_dielectric_in,
    input  logic signed [COEF_W-1:0] s_slope_in,
    input  logic signed [COEF_W-1:0] s_intercept_in,
    output logic [STAT_W-1:0]        m_status,
    output logic [PTS_W-1:0]         m_points_held,
    output logic signed [COEF_W-1:0] m_slope_out,
    output logic signed [COEF_W-1:0] m_intercept_out,
    output logic signed [COEF_W-1:0] m_dielectric_out
);

    op_t                      op_reg;
    logic [X_W-1:0]           x_reg;
    logic signed [Y_W-1:0]    y_reg;
    logic signed [COEF_W-1:0] sin_reg;
    logic signed [COEF_W-1:0] iin_reg;

    logic [CNT_W-1:0]         cnt_reg;
    logic [SX_W-1:0]          sx_reg;
    logic signed [SY_W-1:0]   sy_reg;
    logic [SXX_W-1:0]         sxx_reg;
    logic signed [SXY_W-1:0]  sxy_reg;
    logic signed [COEF_W-1:0] slope_reg;
    logic signed [COEF_W-1:0] icpt_reg;

    logic signed [PROD_W-1:0] prod_reg;
    logic signed [PROD_W-1:0] acc_reg;
    logic signed [ACC_W-1:0]  den_reg;
    logic signed [ACC_W-1:0]  nums_reg;
    logic signed [ACC_W-1:0]  numb_reg;
    logic signed [RND_W-1:0]  rnd_reg;
    logic signed [COEF_W-1:0] conv_reg;

    status_t                  out_status_reg;
    logic [PTS_W-1:0]         out_pts_reg;
    logic signed [COEF_W-1:0] out_slope_reg;
    logic signed [COEF_W-1:0] out_icpt_reg;
    logic signed [COEF_W-1:0] out_diel_reg;

    logic signed [MUL_W-1:0]  x_s, y_s, n_s, sx_s, sy_s, sxx_s, sxy_s, slope_s;
    logic signed [MUL_W-1:0]  mul_a, mul_b;
    logic signed [ACC_W-1:0]  diff;
    logic signed [PROD_W:0]   p_rnd;
    logic signed [RND_W:0]    csum;
    logic signed [COEF_W-1:0] csat;
    logic                     div_done;
    logic signed [COEF_W-1:0] div_quot;

    assign x_s     = MUL_W'($signed({1'b0, x_reg}));
    assign y_s     = MUL_W'(y_reg);
    assign n_s     = MUL_W'($signed({1'b0, cnt_reg}));
    assign sx_s    = MUL_W'($signed({1'b0, sx_reg}));
    assign sy_s    = MUL_W'(sy_reg);
    assign sxx_s   = MUL_W'($signed({1'b0, sxx_reg}));
    assign sxy_s   = MUL_W'(sxy_reg);
    assign slope_s = MUL_W'(slope_reg);

    always_comb begin
        unique case (cmd.mul_sel)
            MUL_XX:      begin mul_a = x_s;     mul_b = x_s;   end
            MUL_XY:      begin mul_a = x_s;     mul_b = y_s;   end
            MUL_N_SXX:   begin mul_a = n_s;     mul_b = sxx_s; end
            MUL_SX_SX:   begin mul_a = sx_s;    mul_b = sx_s;  end
            MUL_N_SXY:   begin mul_a = n_s;     mul_b = sxy_s; end
            MUL_SX_SY:   begin mul_a = sx_s;    mul_b = sy_s;  end
            MUL_SY_SXX:  begin mul_a = sy_s;    mul_b = sxx_s; end
            MUL_SX_SXY:  begin mul_a = sx_s;    mul_b = sxy_s; end
            MUL_SLOPE_X: begin mul_a = slope_s; mul_b = x_s;   end
            default:     begin mul_a = '0;      mul_b = '0;    end
        endcase
    end

    assign diff  = ACC_W'(acc_reg) - ACC_W'(prod_reg);
    assign p_rnd = (PROD_W+1)'(prod_reg)
                 + (prod_reg[PROD_W-1] ? (PROD_W+1)'(RND_HALF - 1) : (PROD_W+1)'(RND_HALF));
    assign csum  = (RND_W+1)'(rnd_reg) + (RND_W+1)'(icpt_reg);

    always_comb begin
        if (csum > (RND_W+1)'(COEF_MAX)) begin
            csat = COEF_MAX;
        end else if (csum < (RND_W+1)'(COEF_MIN)) begin
            csat = COEF_MIN;
        end else begin
            csat = csum[COEF_W-1:0];
        end
    end

    lslc_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (cmd.div_start),
        .sel_b   (cmd.div_sel_b),
        .num     (cmd.div_sel_b ? numb_reg : nums_reg),
        .den     (den_reg[DEN_W-1:0]),
        .done    (div_done),
        .quot    (div_quot)
    );

    assign sts.op       = op_reg;
    assign sts.full     = (cnt_reg >= CNT_MAX);
    assign sts.den_pos  = !den_reg[ACC_W-1] && (den_reg != '0);
    assign sts.div_done = div_done;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg   <= '0;
            sx_reg    <= '0;
            sy_reg    <= '0;
            sxx_reg   <= '0;
            sxy_reg   <= '0;
            slope_reg <= '0;
            icpt_reg  <= '0;
        end else begin
            if (cmd.sxx_add) begin
                sxx_reg <= sxx_reg + prod_reg[SXX_W-1:0];
            end
            if (cmd.sums_upd) begin
                sxy_reg <= sxy_reg + $signed(prod_reg[SXY_W-1:0]);
                sx_reg  <= sx_reg + SX_W'(x_reg);
                sy_reg  <= sy_reg + SY_W'(y_reg);
                cnt_reg <= cnt_reg + CNT_W'(1);
            end
            if (cmd.coef_set) begin
                slope_reg <= sin_reg;
                icpt_reg  <= iin_reg;
            end
            if (cmd.slope_wr) begin
                slope_reg <= div_quot;
            end
            if (cmd.icpt_wr) begin
                icpt_reg <= div_quot;
            end
        end
    end

    always_ff @(posedge aclk) begin
        prod_reg <= mul_a * mul_b;
        if (cmd.capture) begin
            op_reg  <= op_t'(s_op);
            x_reg   <= s_adc_value;
            y_reg   <= s_dielectric_in;
            sin_reg <= s_slope_in;
            iin_reg <= s_intercept_in;
        end
        if (cmd.acc_load) begin
            acc_reg <= prod_reg;
        end
        if (cmd.den_load) begin
            den_reg <= diff;
        end
        if (cmd.nums_load) begin
            nums_reg <= diff;
        end
        if (cmd.numb_load) begin
            numb_reg <= diff;
        end
        if (cmd.conv_rnd) begin
            rnd_reg <= $signed(p_rnd[PROD_W:CONV_SH]);
        end
        if (cmd.conv_sum) begin
            conv_reg <= csat;
        end
        if (cmd.out_load) begin
            out_status_reg <= cmd.out_status;
            out_pts_reg    <= PTS_W'(cnt_reg);
            out_slope_reg  <= slope_reg;
            out_icpt_reg   <= icpt_reg;
            out_diel_reg   <= (op_reg == OP_CONV) ? conv_reg : '0;
        end
    end

    assign m_status         = out_status_reg;
    assign m_points_held    = out_pts_reg;
    assign m_slope_out      = out_slope_reg;
    assign m_intercept_out  = out_icpt_reg;
    assign m_dielectric_out = out_diel_reg;

endmodule

`default_nettype wire

// ----- src/lslc_ctrl.sv -----
// ----------------------------------------------------------------------------
// lslc_ctrl
// Sequencer for add, fit, convert and set words; owns both handshakes.
// ----------------------------------------------------------------------------
`default_nettype none

module lslc_ctrl import lslc_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    output logic      m_valid,
    input  logic      m_ready,
    input  lslc_sts_t sts,
    output lslc_cmd_t cmd
);

    typedef enum logic [16:0] {
        S_IDLE  = 17'h00001,
        S_DISP  = 17'h00002,
        S_ADD1  = 17'h00004,
        S_ADD2  = 17'h00008,
        S_FIT1  = 17'h00010,
        S_FIT2  = 17'h00020,
        S_FIT3  = 17'h00040,
        S_FIT4  = 17'h00080,
        S_FIT5  = 17'h00100,
        S_FIT6  = 17'h00200,
        S_DIVS  = 17'h00400,
        S_WAITS = 17'h00800,
        S_DIVB  = 17'h01000,
        S_WAITB = 17'h02000,
        S_CONV1 = 17'h04000,
        S_CONV2 = 17'h08000,
        S_DONE  = 17'h10000
    } state_t;

    state_t  state_reg, state_next;
    status_t status_reg, status_next;
    logic    m_valid_reg, m_valid_next;

    assign s_ready = (state_reg == S_IDLE);
    assign m_valid = m_valid_reg;

    always_comb begin
        cmd         = '0;
        state_next  = state_reg;
        status_next = status_reg;
        unique case (state_reg)
            S_IDLE: begin
                cmd.capture = s_valid;
                if (s_valid) begin
                    status_next = ST_OK;
                    state_next  = S_DISP;
                end
            end
            S_DISP: begin
                unique case (sts.op)
                    OP_ADD: begin
                        if (sts.full) begin
                            status_next = ST_FULL;
                            state_next  = S_DONE;
                        end else begin
                            cmd.mul_sel = MUL_XX;
                            state_next  = S_ADD1;
                        end
                    end
                    OP_FIT: begin
                        cmd.mul_sel = MUL_N_SXX;
                        state_next  = S_FIT1;
                    end
                    OP_CONV: begin
                        cmd.mul_sel = MUL_SLOPE_X;
                        state_next  = S_CONV1;
                    end
                    OP_SET: begin
                        cmd.coef_set = 1'b1;
                        state_next   = S_DONE;
                    end
                endcase
            end
            S_ADD1: begin
                cmd.sxx_add = 1'b1;
                cmd.mul_sel = MUL_XY;
                state_next  = S_ADD2;
            end
            S_ADD2: begin
                cmd.sums_upd = 1'b1;
                state_next   = S_DONE;
            end
            S_FIT1: begin
                cmd.acc_load = 1'b1;
                cmd.mul_sel  = MUL_SX_SX;
                state_next   = S_FIT2;
            end
            S_FIT2: begin
                cmd.den_load = 1'b1;
                cmd.mul_sel  = MUL_N_SXY;
                state_next   = S_FIT3;
            end
            S_FIT3: begin
                cmd.acc_load = 1'b1;
                cmd.mul_sel  = MUL_SX_SY;
                state_next   = S_FIT4;
            end
            S_FIT4: begin
                cmd.nums_load = 1'b1;
                cmd.mul_sel   = MUL_SY_SXX;
                state_next    = S_FIT5;
            end
            S_FIT5: begin
                cmd.acc_load = 1'b1;
                cmd.mul_sel  = MUL_SX_SXY;
                state_next   = S_FIT6;
            end
            S_FIT6: begin
                cmd.numb_load = 1'b1;
                if (sts.den_pos) begin
                    state_next = S_DIVS;
                end else begin
                    status_next = ST_DEGEN;
                    state_next  = S_DONE;
                end
            end
            S_DIVS: begin
                cmd.div_start = 1'b1;
                state_next    = S_WAITS;
            end
            S_WAITS: begin
                if (sts.div_done) begin
                    cmd.slope_wr = 1'b1;
                    state_next   = S_DIVB;
                end
            end
            S_DIVB: begin
                cmd.div_start = 1'b1;
                cmd.div_sel_b = 1'b1;
                state_next    = S_WAITB;
            end
            S_WAITB: begin
                cmd.div_sel_b = 1'b1;
                if (sts.div_done) begin
                    cmd.icpt_wr = 1'b1;
                    state_next  = S_DONE;
                end
            end
            S_CONV1: begin
                cmd.conv_rnd = 1'b1;
                state_next   = S_CONV2;
            end
            S_CONV2: begin
                cmd.conv_sum = 1'b1;
                state_next   = S_DONE;
            end
            S_DONE: begin
                cmd.out_status = status_reg;
                if (!m_valid_reg || m_ready) begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_comb begin
        m_valid_next = m_valid_reg;
        if (cmd.out_load) begin
            m_valid_next = 1'b1;
        end else if (m_ready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= S_IDLE;
            status_reg  <= ST_OK;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            status_reg  <= status_next;
            m_valid_reg <= m_valid_next;
        end
    end

endmodule

`default_nettype wire

// ----- tb/sv/least_squares_line_calibrator_tb.sv -----
// ----------------------------------------------------------------------------
// least_squares_line_calibrator_tb
// Self-checking bench for the least-squares line calibrator. Words go in on
// the s_ channel and come back on the m_ channel. Each accepted input word
// is run through a behavioral copy of the point sums, the shared-divisor fit,
// the rounded and saturated conversion and the coefficient load. The copy
// queues one predicted report per word, and every report taken from the
// block is compared field by field with the oldest queued one. Directed
// words cover the empty and one-point fits, equal readings, saturating fits
// and conversions, rounding ties and the full point store. Random traffic
// then runs under several idle and stall mixes, including a long output
// hold-off that backs the block up into its input.
// ----------------------------------------------------------------------------
module least_squares_line_calibrator_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import lslc_pkg::*;

    localparam int CYCLE_LIMIT  = 1000000;
    localparam int TAIL_CYCLES  = 100;
    localparam int RANDOM_WORDS = 420;

    typedef struct packed {
        status_t           status;
        logic [PTS_W-1:0]  points;
        logic [COEF_W-1:0] slope;
        logic [COEF_W-1:0] intercept;
        logic [COEF_W-1:0] dielectric;
    } calib_report_t;

    logic                     aclk = 1'b0;
    logic                     aresetn = 1'b0;
    logic                     s_valid = 1'b0;
    logic                     s_ready;
    logic [OP_W-1:0]          s_op = '0;
    logic [X_W-1:0]           s_adc_value = '0;
    logic signed [Y_W-1:0]    s_dielectric_in = '0;
    logic signed [COEF_W-1:0] s_slope_in = '0;
    logic signed [COEF_W-1:0] s_intercept_in = '0;
    logic                     m_valid;
    logic                     m_ready = 1'b0;
    logic [STAT_W-1:0]        m_status;
    logic [PTS_W-1:0]         m_points_held;
    logic signed [COEF_W-1:0] m_slope_out;
    logic signed [COEF_W-1:0] m_intercept_out;
    logic signed [COEF_W-1:0] m_dielectric_out;

    calib_report_t reports_due[$];

    int     cal_count;
    longint cal_sum_x;
    longint cal_sum_y;
    longint cal_sum_xx;
    longint cal_sum_xy;
    logic signed [COEF_W-1:0] cal_slope;
    logic signed [COEF_W-1:0] cal_intercept;

    int sender_idle_pct = 0;
    int receiver_stall_pct = 0;
    int hold_off_cycles = 0;
    int mismatches = 0;
    int cycle_count = 0;

    least_squares_line_calibrator DUT (
        .aclk             (aclk),
        .aresetn          (aresetn),
        .s_valid          (s_valid),
        .s_ready          (s_ready),
        .s_op             (s_op),
        .s_adc_value      (s_adc_value),
        .s_dielectric_in  (s_dielectric_in),
        .s_slope_in       (s_slope_in),
        .s_intercept_in   (s_intercept_in),
        .m_valid          (m_valid),
        .m_ready          (m_ready),
        .m_status         (m_status),
        .m_points_held    (m_points_held),
        .m_slope_out      (m_slope_out),
        .m_intercept_out  (m_intercept_out),
        .m_dielectric_out (m_dielectric_out)
    );

    initial begin
        forever #5 aclk = ~aclk;
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    function automatic longint round_div(input longint num, input longint den);
        longint mag;
        mag = (num < 0) ? -num : num;
        mag = (mag + den / 2) / den;
        return (num < 0) ? -mag : mag;
    endfunction

    function automatic logic signed [COEF_W-1:0] clamp32(input longint v);
        if (v > longint'(COEF_MAX)) return COEF_MAX;
        if (v < longint'(COEF_MIN)) return COEF_MIN;
        return v[COEF_W-1:0];
    endfunction

    task automatic compute_calibration(input op_t op, input logic [X_W-1:0] adc,
                                       input logic signed [Y_W-1:0] diel,
                                       input logic signed [COEF_W-1:0] slope_w,
                                       input logic signed [COEF_W-1:0] icpt_w);
        calib_report_t rep;
        longint x;
        longint y;
        longint n;
        longint den;
        longint num_slope;
        longint num_icpt;
        x = longint'(adc);
        y = longint'(diel);
        rep = '0;
        rep.status = ST_OK;
        case (op)
            OP_ADD: begin
                if (cal_count >= MAX_POINTS) begin
                    rep.status = ST_FULL;
                end else begin
                    cal_sum_x += x;
                    cal_sum_y += y;
                    cal_sum_xx += x * x;
                    cal_sum_xy += x * y;
                    cal_count++;
                end
            end
            OP_FIT: begin
                n = longint'(cal_count);
                den = n * cal_sum_xx - cal_sum_x * cal_sum_x;
                if (den <= 0) begin
                    rep.status = ST_DEGEN;
                end else begin
                    num_slope = (n * cal_sum_xy - cal_sum_x * cal_sum_y) * 65536;
                    num_icpt = (cal_sum_y * cal_sum_xx - cal_sum_x * cal_sum_xy) * 256;
                    cal_slope = clamp32(round_div(num_slope, den));
                    cal_intercept = clamp32(round_div(num_icpt, den));
                end
            end
            OP_CONV: begin
                rep.dielectric = clamp32(round_div(longint'(cal_slope) * x, 256)
                                         + longint'(cal_intercept));
            end
            default: begin
                cal_slope = slope_w;
                cal_intercept = icpt_w;
            end
        endcase
        rep.points = PTS_W'(cal_count);
        rep.slope = cal_slope;
        rep.intercept = cal_intercept;
        reports_due.push_back(rep);
    endtask

    task automatic offer_word(input op_t op, input logic [X_W-1:0] adc,
                              input logic signed [Y_W-1:0] diel,
                              input logic signed [COEF_W-1:0] slope_w,
                              input logic signed [COEF_W-1:0] icpt_w);
        @(negedge aclk);
        while ($urandom_range(99) < sender_idle_pct) begin
            s_valid <= 1'b0;
            @(negedge aclk);
        end
        s_valid <= 1'b1;
        s_op <= op;
        s_adc_value <= adc;
        s_dielectric_in <= diel;
        s_slope_in <= slope_w;
        s_intercept_in <= icpt_w;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        compute_calibration(op, adc, diel, slope_w, icpt_w);
    endtask

    task automatic await_reports();
        @(negedge aclk);
        s_valid <= 1'b0;
        while (reports_due.size() != 0) @(posedge aclk);
    endtask

    function automatic logic [X_W-1:0] rand_adc();
        case ($urandom_range(7))
            0: return '0;
            1: return '1;
            default: return X_W'($urandom_range(1023));
        endcase
    endfunction

    function automatic logic signed [COEF_W-1:0] rand_coef();
        case ($urandom_range(4))
            0: return $urandom;
            1: return $signed(COEF_W'($urandom_range(65535))) - 32768;
            2: return $signed(COEF_W'($urandom_range(1048575))) - 524288;
            3: return $signed(COEF_W'($urandom_range(16777215))) - 8388608;
            default: begin
                case ($urandom_range(3))
                    0: return COEF_MAX;
                    1: return COEF_MIN;
                    2: return '0;
                    default: return '1;
                endcase
            end
        endcase
    endfunction

    always @(negedge aclk) begin
        if (hold_off_cycles > 0) begin
            m_ready <= 1'b0;
            hold_off_cycles = hold_off_cycles - 1;
        end else begin
            m_ready <= ($urandom_range(99) >= receiver_stall_pct);
        end
    end

    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s mismatch: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endtask

    always @(posedge aclk) begin
        calib_report_t want;
        if (aresetn && m_valid && m_ready) begin
            if (reports_due.size() == 0) begin
                $error("report word with nothing outstanding");
                mismatches++;
            end else begin
                want = reports_due.pop_front();
                check_field("status", longint'(want.status), longint'(m_status));
                check_field("points_held", longint'(want.points), longint'(m_points_held));
                check_field("slope_out", longint'($signed(want.slope)),
                            longint'(m_slope_out));
                check_field("intercept_out", longint'($signed(want.intercept)),
                            longint'(m_intercept_out));
                check_field("dielectric_out", longint'($signed(want.dielectric)),
                            longint'(m_dielectric_out));
            end
        end
    end

    task automatic test_empty_store();
        offer_word(OP_CONV, '1, Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_FIT, X_W'($urandom), Y_W'($urandom), $urandom, $urandom);
    endtask

    task automatic test_degenerate_fits();
        offer_word(OP_ADD, '1, 16'sh7fff, $urandom, $urandom);
        offer_word(OP_FIT, X_W'($urandom), Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_ADD, '1, 16'sh7fff, $urandom, $urandom);
        offer_word(OP_FIT, X_W'($urandom), Y_W'($urandom), $urandom, $urandom);
    endtask

    task automatic test_saturating_fit();
        offer_word(OP_ADD, 10'd1022, 16'sh8000, $urandom, $urandom);
        offer_word(OP_FIT, X_W'($urandom), Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_CONV, '1, Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_CONV, '0, Y_W'($urandom), $urandom, $urandom);
    endtask

    task automatic test_coefficient_load();
        offer_word(OP_SET, X_W'($urandom), Y_W'($urandom), COEF_MAX, COEF_MAX);
        offer_word(OP_CONV, '1, Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_SET, X_W'($urandom), Y_W'($urandom), COEF_MIN, COEF_MIN);
        offer_word(OP_CONV, '1, Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_SET, X_W'($urandom), Y_W'($urandom), 32'sd128, -32'sd1);
        offer_word(OP_CONV, 10'd1, Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_SET, X_W'($urandom), Y_W'($urandom), -32'sd128, 32'sd0);
        offer_word(OP_CONV, 10'd1, Y_W'($urandom), $urandom, $urandom);
    endtask

    task automatic test_store_full();
        while (cal_count < MAX_POINTS)
            offer_word(OP_ADD, rand_adc(), Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_ADD, rand_adc(), Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_FIT, X_W'($urandom), Y_W'($urandom), $urandom, $urandom);
        offer_word(OP_CONV, rand_adc(), Y_W'($urandom), $urandom, $urandom);
    endtask

    task automatic offer_random_word(output bit counted);
        int pick;
        op_t op;
        pick = $urandom_range(99);
        if (pick < 10) op = OP_ADD;
        else if (pick < 25) op = OP_FIT;
        else if (pick < 70) op = OP_CONV;
        else op = OP_SET;
        counted = (op != OP_ADD);
        offer_word(op, rand_adc(), Y_W'($urandom), rand_coef(), rand_coef());
    endtask

    task automatic test_output_backpressure();
        bit counted;
        await_reports();
        sender_idle_pct = 0;
        receiver_stall_pct = 0;
        hold_off_cycles = 400;
        repeat (12) offer_random_word(counted);
        await_reports();
    endtask

    task automatic test_random_traffic(input int idle_pct, input int stall_pct);
        int done;
        bit counted;
        sender_idle_pct = idle_pct;
        receiver_stall_pct = stall_pct;
        done = 0;
        while (done < RANDOM_WORDS) begin
            offer_random_word(counted);
            if (counted) done++;
        end
        await_reports();
    endtask

    initial begin
        cal_count = 0;
        cal_sum_x = 0;
        cal_sum_y = 0;
        cal_sum_xx = 0;
        cal_sum_xy = 0;
        cal_slope = '0;
        cal_intercept = '0;
        repeat (5) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_empty_store();
        test_degenerate_fits();
        test_saturating_fit();
        test_coefficient_load();
        test_store_full();
        test_output_backpressure();
        test_random_traffic(0, 0);
        test_random_traffic(86, 0);
        test_random_traffic(0, 86);
        test_random_traffic(12, 12);

        await_reports();
        repeat (TAIL_CYCLES) @(posedge aclk);
        if (mismatches == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end
endmodule

// ----- least_squares_line_calibrator.f -----
+incdir+src
src/lslc_pkg.sv
src/lslc_div.sv
src/lslc_dpath.sv
src/lslc_ctrl.sv
src/least_squares_line_calibrator.sv
tb/sv/least_squares_line_calibrator_tb.sv
